>>> hdl/nrsp_pkg.sv
package nrsp_pkg;

   localparam int unsigned HDR_BYTES     = 12;
   localparam int unsigned NOTE_MAX      = 127;
   localparam int unsigned MIN_LEN_RESET = 10;
   localparam int unsigned RSP_DEPTH     = 4;

   localparam logic       KIND_RECORD = 1'b0;
   localparam logic       KIND_STATUS = 1'b1;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_SHORT  = 2'd1;
   localparam logic [1:0] STATUS_CHECK  = 2'd2;
   localparam logic [1:0] STATUS_STRIDE = 2'd3;

   localparam logic       REG_BIG_ENDIAN = 1'b0;
   localparam logic       REG_MIN_LENGTH = 1'b1;

   typedef struct packed {
      logic               kind;
      logic signed [31:0] note_begin;
      logic signed [31:0] note_length;
      logic [31:0]        note_number;
      logic               accepted;
      logic [1:0]         status;
      logic [31:0]        valid_count;
      logic               last_result;
   } rsp_type;

   function automatic logic [31:0] push_byte(input logic [31:0] w, input logic [7:0] b,
                                             input logic big_endian);
      if (big_endian) begin
         return {w[23:0], b};
      end
      return {b, w[31:8]};
   endfunction

endpackage

>>> hdl/nrsp_rsp_queue.sv
module nrsp_rsp_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push0,
   input  logic             push1,
   input  nrsp_pkg::rsp_type data0,
   input  nrsp_pkg::rsp_type data1,
   output logic             has_room,
   output logic             out_valid,
   input  logic             out_ready,
   output nrsp_pkg::rsp_type out_data
);
   import nrsp_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   rsp_type        entry_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in, wr_next;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           pop;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      if (p == PW'(DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   // push1 only ever comes with push0
   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign has_room  = (count_ff <= CW'(DEPTH - 2));
   assign wr_next   = bump(wr_ptr_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push1) begin
         wr_ptr_in = bump(wr_next);
      end else if (push0) begin
         wr_ptr_in = wr_next;
      end
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push0) + CW'(push1) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         entry_ff[wr_ptr_ff] <= data0;
      end
      if (push1) begin
         entry_ff[wr_next] <= data1;
      end
   end

endmodule

>>> hdl/note_record_stream_parser.sv
// channel  direction  payload                                         handshake
// req      in         data_byte, last_byte                            req_valid/req_ready
// rsp      out        kind, note_begin/length/number, accepted,       rsp_valid/rsp_ready
//                     status, valid_count, last_result
// csr      in/out     big_endian (0x0), min_note_length (0x4)         APB, pready tied high
//
// One byte is taken per cycle while req_ready is high; its results are worked out in
// the same cycle and land in a small result queue, which hands them to rsp in order.
// A byte that yields a record and the status puts two entries in the queue; req_ready
// drops only while the queue cannot take two more.
// Synchronous reset clears the run state and the queue and sets the registers to
// their defaults (little endian, minimum length 10).
module note_record_stream_parser #(
   parameter int unsigned RSP_DEPTH = nrsp_pkg::RSP_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_kind,
   output logic signed [31:0] rsp_note_begin,
   output logic signed [31:0] rsp_note_length,
   output logic [31:0]        rsp_note_number,
   output logic               rsp_accepted,
   output logic [1:0]         rsp_status,
   output logic [31:0]        rsp_valid_count,
   output logic               rsp_last_result,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import nrsp_pkg::*;

   logic        big_endian_ff;
   logic [30:0] min_len_ff;

   logic [3:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [1:0]  lane_ff, lane_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] stride_ff, stride_in;
   logic [31:0] expect_ff, expect_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] seg_pos_ff, seg_pos_in;
   logic [31:0] field_ff [3];
   logic [31:0] field_in [3];
   logic [31:0] last_begin_ff, last_begin_in;
   logic        have_ff, have_in;
   logic [31:0] total_ff, total_in;
   logic        seen_ff, seen_in;

   logic        accept;
   logic        rec_valid;
   logic        rec_ok;
   rsp_type     rec, stat, q_out;
   logic [1:0]  k;

   assign accept     = req_valid && req_ready;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr[2])
         REG_BIG_ENDIAN: csr_prdata = {31'd0, big_endian_ff};
         REG_MIN_LENGTH: csr_prdata = {1'b0, min_len_ff};
         default:        csr_prdata = '0;
      endcase
   end

   always_comb begin
      hdr_cnt_in    = (hdr_cnt_ff < 4'(HDR_BYTES)) ? hdr_cnt_ff + 4'd1 : hdr_cnt_ff;
      lane_in       = lane_ff + 2'd1;
      shift_in      = push_byte(shift_ff, req_data_byte, big_endian_ff);
      stride_in     = stride_ff;
      expect_in     = expect_ff;
      acc_in        = acc_ff;
      seg_pos_in    = seg_pos_ff;
      field_in      = field_ff;
      last_begin_in = last_begin_ff;
      have_in       = have_ff;
      total_in      = total_ff;
      seen_in       = seen_ff;
      rec_valid     = 1'b0;
      rec_ok        = 1'b1;
      k             = seg_pos_ff[3:2];

      if (hdr_cnt_ff < 4'(HDR_BYTES)) begin
         if (hdr_cnt_ff == 4'd7) begin
            stride_in = shift_in;
         end else if (hdr_cnt_ff == 4'd11) begin
            expect_in = shift_in;
         end
      end else begin
         if (lane_ff == 2'd3) begin
            acc_in = acc_ff ^ shift_in;
         end
         if (stride_ff >= 32'(HDR_BYTES)) begin
            if (seg_pos_ff < 32'(HDR_BYTES)) begin
               field_in[k] = push_byte(field_ff[k], req_data_byte, big_endian_ff);
            end
            if (seg_pos_ff == stride_ff - 32'd1) begin
               rec_valid = 1'b1;
               if (have_ff && !($signed(field_in[0]) > $signed(last_begin_ff))) begin
                  rec_ok = 1'b0;
               end
               if (field_in[1][31] || (field_in[1][30:0] < min_len_ff)) begin
                  rec_ok = 1'b0;
               end
               if (field_in[2] == 32'd0 || field_in[2] > 32'(NOTE_MAX)) begin
                  rec_ok = 1'b0;
               end
               if (rec_ok) begin
                  last_begin_in = field_in[0];
                  have_in       = 1'b1;
                  total_in      = total_ff + 32'd1;
               end
               seen_in    = 1'b1;
               seg_pos_in = '0;
            end else begin
               seg_pos_in = seg_pos_ff + 32'd1;
            end
         end
      end

      rec.kind        = KIND_RECORD;
      rec.note_begin  = $signed(field_in[0]);
      rec.note_length = $signed(field_in[1]);
      rec.note_number = field_in[2];
      rec.accepted    = rec_ok;
      rec.status      = STATUS_OK;
      rec.valid_count = '0;
      rec.last_result = 1'b0;

      stat             = '0;
      stat.kind        = KIND_STATUS;
      stat.last_result = 1'b1;
      // status sees the state as this byte leaves it
      priority if (hdr_cnt_ff < 4'(HDR_BYTES - 1)) begin
         stat.status = STATUS_SHORT;
      end else if (stride_in < 32'(HDR_BYTES)) begin
         stat.status = STATUS_STRIDE;
      end else if (seen_in && acc_in != expect_in) begin
         stat.status = STATUS_CHECK;
      end else begin
         stat.status      = STATUS_OK;
         stat.valid_count = total_in;
      end

      if (rec_valid) begin
         field_in[0] = '0;
         field_in[1] = '0;
         field_in[2] = '0;
      end

      if (req_last_byte) begin
         hdr_cnt_in    = '0;
         lane_in       = '0;
         shift_in      = '0;
         stride_in     = '0;
         expect_in     = '0;
         acc_in        = '0;
         seg_pos_in    = '0;
         field_in[0]   = '0;
         field_in[1]   = '0;
         field_in[2]   = '0;
         last_begin_in = '0;
         have_in       = 1'b0;
         total_in      = '0;
         seen_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         big_endian_ff <= 1'b0;
         min_len_ff    <= 31'(MIN_LEN_RESET);
         hdr_cnt_ff    <= '0;
         lane_ff       <= '0;
         shift_ff      <= '0;
         stride_ff     <= '0;
         expect_ff     <= '0;
         acc_ff        <= '0;
         seg_pos_ff    <= '0;
         field_ff[0]   <= '0;
         field_ff[1]   <= '0;
         field_ff[2]   <= '0;
         last_begin_ff <= '0;
         have_ff       <= 1'b0;
         total_ff      <= '0;
         seen_ff       <= 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            unique case (csr_paddr[2])
               REG_BIG_ENDIAN: big_endian_ff <= csr_pwdata[0];
               REG_MIN_LENGTH: min_len_ff    <= csr_pwdata[30:0];
               default: ;
            endcase
         end
         if (accept) begin
            hdr_cnt_ff    <= hdr_cnt_in;
            lane_ff       <= lane_in;
            shift_ff      <= shift_in;
            stride_ff     <= stride_in;
            expect_ff     <= expect_in;
            acc_ff        <= acc_in;
            seg_pos_ff    <= seg_pos_in;
            field_ff      <= field_in;
            last_begin_ff <= last_begin_in;
            have_ff       <= have_in;
            total_ff      <= total_in;
            seen_ff       <= seen_in;
         end
      end
   end

   nrsp_rsp_queue #(
      .DEPTH(RSP_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push0     (accept && (rec_valid || req_last_byte)),
      .push1     (accept && rec_valid && req_last_byte),
      .data0     (rec_valid ? rec : stat),
      .data1     (stat),
      .has_room  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (q_out)
   );

   assign rsp_kind        = q_out.kind;
   assign rsp_note_begin  = q_out.note_begin;
   assign rsp_note_length = q_out.note_length;
   assign rsp_note_number = q_out.note_number;
   assign rsp_accepted    = q_out.accepted;
   assign rsp_status      = q_out.status;
   assign rsp_valid_count = q_out.valid_count;
   assign rsp_last_result = q_out.last_result;

endmodule

>>> sim/testbench.sv
module testbench;
   import nrsp_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_BYTES   = 260;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_data_byte = 8'h00;
   logic               req_last_byte = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_kind;
   logic signed [31:0] rsp_note_begin;
   logic signed [31:0] rsp_note_length;
   logic [31:0]        rsp_note_number;
   logic               rsp_accepted;
   logic [1:0]         rsp_status;
   logic [31:0]        rsp_valid_count;
   logic               rsp_last_result;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [2:0]         csr_paddr = 3'd0;
   logic [31:0]        csr_pwdata = 32'd0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   note_record_stream_parser dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_note_begin  (rsp_note_begin),
      .rsp_note_length (rsp_note_length),
      .rsp_note_number (rsp_note_number),
      .rsp_accepted    (rsp_accepted),
      .rsp_status      (rsp_status),
      .rsp_valid_count (rsp_valid_count),
      .rsp_last_result (rsp_last_result),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // register shadows
   logic        cfg_big = 1'b0;
   logic [30:0] cfg_min = 31'(MIN_LEN_RESET);

   // parser shadow state
   logic [31:0] byte_count;
   logic [31:0] word_reg;
   logic [31:0] stride_reg;
   logic [31:0] check_word;
   logic [31:0] running_xor;
   logic [31:0] seg_offset;
   logic [31:0] seg_field [3];
   logic [31:0] prev_begin;
   logic        begin_valid;
   logic [31:0] accept_count;
   logic [31:0] seg_count;

   rsp_type     pending_results [$];
   int          failures = 0;
   int          cycle_count = 0;
   int          sent_bytes = 0;
   int          burst_left = 0;
   bit          pace_on = 1'b0;
   int          stall_mode = 0;
   int          stall_left = 0;
   logic [7:0]  file_bytes [$];
   logic [7:0]  body_bytes [$];

   function automatic logic [31:0] shift_in(input logic [31:0] word, input logic [7:0] b);
      return cfg_big ? {word[23:0], b} : {b, word[31:8]};
   endfunction

   task automatic clear_parser();
      byte_count   = '0;
      word_reg     = '0;
      stride_reg   = '0;
      check_word   = '0;
      running_xor  = '0;
      seg_offset   = '0;
      seg_field    = '{default: '0};
      prev_begin   = '0;
      begin_valid  = 1'b0;
      accept_count = '0;
      seg_count    = '0;
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic last);
      logic [31:0] pos;
      logic [31:0] sp;
      logic        ok;
      rsp_type     r;
      pos = byte_count;
      word_reg = shift_in(word_reg, b);
      if (pos < HDR_BYTES) begin
         if (pos == 32'd7) begin
            stride_reg = word_reg;
         end else if (pos == 32'd11) begin
            check_word = word_reg;
         end
      end else begin
         if (pos[1:0] == 2'b11) begin
            running_xor ^= word_reg;
         end
         if (stride_reg >= HDR_BYTES) begin
            sp = seg_offset;
            if (sp < HDR_BYTES) begin
               seg_field[sp[3:2]] = shift_in(seg_field[sp[3:2]], b);
            end
            if (sp == stride_reg - 32'd1) begin
               ok = 1'b1;
               if (begin_valid && !($signed(seg_field[0]) > $signed(prev_begin))) begin
                  ok = 1'b0;
               end
               if (seg_field[1][31] || seg_field[1] < {1'b0, cfg_min}) begin
                  ok = 1'b0;
               end
               if (seg_field[2] == 32'd0 || seg_field[2] > NOTE_MAX) begin
                  ok = 1'b0;
               end
               if (ok) begin
                  prev_begin   = seg_field[0];
                  begin_valid  = 1'b1;
                  accept_count = accept_count + 32'd1;
               end
               if (seg_count != 32'hFFFF_FFFF) begin
                  seg_count = seg_count + 32'd1;
               end
               r             = '0;
               r.kind        = KIND_RECORD;
               r.note_begin  = seg_field[0];
               r.note_length = seg_field[1];
               r.note_number = seg_field[2];
               r.accepted    = ok;
               pending_results.push_back(r);
               seg_offset = '0;
               seg_field  = '{default: '0};
            end else begin
               seg_offset = sp + 32'd1;
            end
         end
      end
      byte_count = (pos == 32'hFFFF_FFFF) ? 32'hFFFF_FFFC : pos + 32'd1;
      if (last) begin
         r             = '0;
         r.kind        = KIND_STATUS;
         r.last_result = 1'b1;
         if (pos < HDR_BYTES - 1) begin
            r.status = STATUS_SHORT;
         end else if (stride_reg < HDR_BYTES) begin
            r.status = STATUS_STRIDE;
         end else if (seg_count != 0 && running_xor != check_word) begin
            r.status = STATUS_CHECK;
         end else begin
            r.status      = STATUS_OK;
            r.valid_count = accept_count;
         end
         pending_results.push_back(r);
         clear_parser();
      end
   endtask

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         clear_parser();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual kind %0b status %0d",
                        $time, rsp_kind, rsp_status);
               failures++;
            end else begin
               want = pending_results.pop_front();
               compare_field("kind", 32'(want.kind), 32'(rsp_kind));
               compare_field("note_begin", want.note_begin, rsp_note_begin);
               compare_field("note_length", want.note_length, rsp_note_length);
               compare_field("note_number", want.note_number, rsp_note_number);
               compare_field("accepted", 32'(want.accepted), 32'(rsp_accepted));
               compare_field("status", 32'(want.status), 32'(rsp_status));
               compare_field("valid_count", want.valid_count, rsp_valid_count);
               compare_field("last_result", 32'(want.last_result), 32'(rsp_last_result));
            end
         end
         // request taken at this edge: results can only show from the next one
         if (req_valid && req_ready) begin
            predict_byte(req_data_byte, req_last_byte);
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(16, 160);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (stall_left[2:0] != 3'd0);
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   task automatic idle(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      sent_bytes++;
   endtask

   task automatic pace();
      if (pace_on) begin
         if (burst_left == 0) begin
            idle($urandom_range(1, 6));
            burst_left = $urandom_range(1, 30);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic drain();
      idle(1);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (index == REG_BIG_ENDIAN) begin
         cfg_big = value[0];
      end else begin
         cfg_min = value[30:0];
      end
      @(posedge clock);
   endtask

   task automatic put_word(input logic [31:0] w);
      if (cfg_big) begin
         file_bytes.push_back(w[31:24]);
         file_bytes.push_back(w[23:16]);
         file_bytes.push_back(w[15:8]);
         file_bytes.push_back(w[7:0]);
      end else begin
         file_bytes.push_back(w[7:0]);
         file_bytes.push_back(w[15:8]);
         file_bytes.push_back(w[23:16]);
         file_bytes.push_back(w[31:24]);
      end
   endtask

   // file_bytes holds the payload; put the header in front of it
   task automatic wrap_header(input logic [31:0] stride, input bit corrupt);
      logic [31:0] check;
      logic [31:0] word;
      check = '0;
      word  = '0;
      foreach (file_bytes[i]) begin
         word = shift_in(word, file_bytes[i]);
         if (i % 4 == 3) begin
            check ^= word;
         end
      end
      if (corrupt) begin
         check ^= 32'h1 << $urandom_range(0, 31);
      end
      body_bytes = file_bytes;
      file_bytes = {};
      put_word($urandom);
      put_word(stride);
      put_word(check);
      foreach (body_bytes[i]) begin
         file_bytes.push_back(body_bytes[i]);
      end
   endtask

   task automatic send_file();
      foreach (file_bytes[i]) begin
         send_byte(file_bytes[i], i == file_bytes.size() - 1);
         pace();
      end
   endtask

   task automatic build_note_file();
      logic [31:0] stride;
      logic [31:0] bg;
      logic [31:0] ln;
      logic [31:0] nt;
      int          nseg;
      int          tail;
      int          keep;
      case ($urandom_range(0, 9))
         0: stride = $urandom_range(0, HDR_BYTES - 1);
         1: stride = $urandom;
         default: stride = $urandom_range(HDR_BYTES, 20);
      endcase
      file_bytes = {};
      if (stride >= HDR_BYTES && stride <= 20) begin
         nseg = $urandom_range(0, 6);
         bg = ($urandom_range(0, 3) == 0) ? 32'h7FFF_FF00 + $urandom_range(0, 255) : $urandom;
         for (int s = 0; s < nseg; s++) begin
            case ($urandom_range(0, 9))
               0: bg = $urandom;
               1: bg = bg;
               2: bg = bg - $urandom_range(1, 100);
               default: bg = bg + $urandom_range(1, 1000);
            endcase
            case ($urandom_range(0, 5))
               0, 1, 2: ln = {1'b0, cfg_min} + $urandom_range(0, 3);
               3: ln = {1'b0, cfg_min} - 32'd1;
               4: ln = $urandom;
               default: ln = 32'h8000_0000 | $urandom;
            endcase
            case ($urandom_range(0, 7))
               0: nt = 32'd0;
               1: nt = NOTE_MAX + 1;
               2: nt = $urandom;
               3: nt = NOTE_MAX;
               default: nt = $urandom_range(1, NOTE_MAX);
            endcase
            put_word(bg);
            put_word(ln);
            put_word(nt);
            repeat (stride - HDR_BYTES) file_bytes.push_back(8'($urandom_range(0, 255)));
         end
         tail = $urandom_range(0, 1) ? 0 : $urandom_range(0, stride - 1);
      end else begin
         tail = $urandom_range(0, 40);
      end
      repeat (tail) file_bytes.push_back(8'($urandom_range(0, 255)));
      wrap_header(stride, $urandom_range(0, 4) == 0);
      // broken file: end marker arrives early
      if ($urandom_range(0, 9) == 0) begin
         keep = $urandom_range(1, file_bytes.size());
         while (file_bytes.size() > keep) void'(file_bytes.pop_back());
      end
   endtask

   task automatic run_file_mix(input int budget);
      int start;
      start = sent_bytes;
      while (sent_bytes - start < budget) begin
         pace_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0) begin
            file_bytes = {};
            repeat ($urandom_range(1, 30)) file_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            build_note_file();
         end
         send_file();
         if ($urandom_range(0, 9) == 0) begin
            drain();
         end
      end
   endtask

   task automatic test_short_file();
      pace_on = 1'b0;
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_record_with_status();
      // single segment whose final byte is also the end of file
      file_bytes = {};
      put_word(32'h7FFF_FFFF);
      put_word(MIN_LEN_RESET);
      put_word(NOTE_MAX);
      wrap_header(HDR_BYTES, 1'b0);
      send_file();
      drain();
   endtask

   task automatic test_big_endian_no_minimum();
      drain();
      csr_write(REG_BIG_ENDIAN, 32'd1);
      csr_write(REG_MIN_LENGTH, 32'd0);
      run_file_mix(PHASE_BYTES);
   endtask

   task automatic test_largest_minimum();
      drain();
      csr_write(REG_BIG_ENDIAN, 32'd0);
      csr_write(REG_MIN_LENGTH, 32'h7FFF_FFFF);
      run_file_mix(PHASE_BYTES);
   endtask

   task automatic test_random_minimum();
      drain();
      csr_write(REG_BIG_ENDIAN, 32'd1);
      csr_write(REG_MIN_LENGTH, $urandom_range(0, 2000));
      run_file_mix(PHASE_BYTES);
   endtask

   task automatic test_reset_minimum();
      drain();
      csr_write(REG_BIG_ENDIAN, 32'd0);
      csr_write(REG_MIN_LENGTH, MIN_LEN_RESET);
      run_file_mix(PHASE_BYTES);
   endtask

   task automatic test_wide_minimum();
      drain();
      csr_write(REG_BIG_ENDIAN, 32'd1);
      csr_write(REG_MIN_LENGTH, $urandom & 32'h7FFF_FFFF);
      run_file_mix(PHASE_BYTES);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_file();
      test_record_with_status();
      test_big_endian_no_minimum();
      test_largest_minimum();
      test_random_minimum();
      test_reset_minimum();
      test_wide_minimum();
      drain();
      if (failures == 0 && pending_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/nrsp_pkg.sv
hdl/nrsp_rsp_queue.sv
hdl/note_record_stream_parser.sv
sim/testbench.sv
